// ===== rtl/euler_motion_integrator_top_defines.svh =====
// ----------------------------------------------------------------------------
// Euler motion integrator assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef EULER_MOTION_INTEGRATOR_TOP_DEFINES_SVH
`define EULER_MOTION_INTEGRATOR_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define EMI_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("integrator assertion failed");

// next-cycle implication
`define EMI_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("integrator assertion failed");

`endif

// ===== rtl/emi_pkg.sv =====
// ----------------------------------------------------------------------------
// Euler motion integrator package
// Widths, payload structs and saturation helper shared by the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package emi_pkg;

    localparam int WORD_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int STEP_FRAC  = 32;
    localparam int DIV_BITS   = 4;
    localparam int DIV_STAGES = WORD_WIDTH / DIV_BITS;
    localparam int PIPE_DEPTH = DIV_STAGES + 6;
    localparam int PROD_WIDTH = WORD_WIDTH + STEP_FRAC;
    localparam int SUM_WIDTH  = WORD_WIDTH + 2;

    localparam logic [STEP_FRAC-1:0] TIME_STEP_RESET = STEP_FRAC'(4295);

    typedef logic signed [WORD_WIDTH-1:0] word_t;
    typedef logic [WORD_WIDTH-1:0]        uword_t;
    typedef logic [STEP_FRAC-1:0]         step_t;

    typedef struct packed {
        word_t  pos_x;
        word_t  pos_y;
        word_t  pos_z;
        word_t  vel_x;
        word_t  vel_y;
        word_t  vel_z;
        word_t  force_x;
        word_t  force_y;
        word_t  force_z;
        uword_t body_mass;
    } in_t;

    typedef struct packed {
        word_t new_pos_x;
        word_t new_pos_y;
        word_t new_pos_z;
        word_t new_vel_x;
        word_t new_vel_y;
        word_t new_vel_z;
        word_t accel_x;
        word_t accel_y;
        word_t accel_z;
        logic  mass_zero;
        logic  saturated;
    } out_t;

    typedef struct packed {
        word_t pos;
        word_t vel;
        word_t acc;
        logic  zero;
        logic  sat;
    } lane_out_t;

    // returns {clamped, value}
    function automatic logic [WORD_WIDTH:0] clamp_word(input logic signed [SUM_WIDTH-1:0] v);
        logic signed [SUM_WIDTH-1:0] hi;
        logic signed [SUM_WIDTH-1:0] lo;
        hi = $signed({3'b000, {(WORD_WIDTH-1){1'b1}}});
        lo = $signed({3'b111, {(WORD_WIDTH-1){1'b0}}});
        if (v > hi)
            clamp_word = {1'b1, hi[WORD_WIDTH-1:0]};
        else if (v < lo)
            clamp_word = {1'b1, lo[WORD_WIDTH-1:0]};
        else
            clamp_word = {1'b0, v[WORD_WIDTH-1:0]};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/emi_div_stage.sv =====
// ----------------------------------------------------------------------------
// Divider stage
// Registered restoring division stage, DIV_BITS quotient bits per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module emi_div_stage
    import emi_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   en,
    input  wire uword_t mass,
    input  wire uword_t rem_in,
    input  wire uword_t dq_in,
    output uword_t      rem_reg,
    output uword_t      dq_reg
);

    uword_t rem_next;
    uword_t dq_next;

    // dq holds the dividend bits still to come, quotient bits shift in at the bottom
    always_comb
    begin
        logic [WORD_WIDTH:0] t;
        rem_next = rem_in;
        dq_next  = dq_in;
        for (int i = 0; i < DIV_BITS; i++)
        begin
            t       = {rem_next, dq_next[WORD_WIDTH-1]};
            dq_next = {dq_next[WORD_WIDTH-2:0], 1'b0};
            if (t >= {1'b0, mass})
            begin
                rem_next   = WORD_WIDTH'(t - {1'b0, mass});
                dq_next[0] = 1'b1;
            end
            else
            begin
                rem_next = t[WORD_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            dq_reg  <= dq_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/emi_lane.sv =====
// ----------------------------------------------------------------------------
// Axis lane
// One axis: force / mass, velocity update, position update, with saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module emi_lane
    import emi_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   en,
    input  wire word_t  pos,
    input  wire word_t  vel,
    input  wire word_t  force_in,
    input  wire uword_t mass,
    input  wire step_t  step,
    output lane_out_t   res_reg
);

    // divider chain, index 0 is the entry register
    uword_t rem_s  [0:DIV_STAGES];
    uword_t dq_s   [0:DIV_STAGES];
    uword_t mass_s [0:DIV_STAGES];
    word_t  pos_s  [0:DIV_STAGES];
    word_t  vel_s  [0:DIV_STAGES];
    logic   sign_s [0:DIV_STAGES];
    logic   ovf_s  [0:DIV_STAGES];

    uword_t fmag;
    uword_t hi_next;
    uword_t rem0_reg;
    uword_t dq0_reg;

    assign fmag    = force_in[WORD_WIDTH-1] ? uword_t'(-force_in) : uword_t'(force_in);
    assign hi_next = fmag >> (WORD_WIDTH - FRAC_BITS);

    assign rem_s[0] = rem0_reg;
    assign dq_s[0]  = dq0_reg;

    // entry register and sideband chain alongside the divider stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem0_reg  <= hi_next;
            dq0_reg   <= fmag << FRAC_BITS;
            ovf_s[0]  <= (hi_next >= mass);
            sign_s[0] <= force_in[WORD_WIDTH-1];
            mass_s[0] <= mass;
            pos_s[0]  <= pos;
            vel_s[0]  <= vel;
            for (int k = 0; k < DIV_STAGES; k++)
            begin
                mass_s[k+1] <= mass_s[k];
                pos_s[k+1]  <= pos_s[k];
                vel_s[k+1]  <= vel_s[k];
                sign_s[k+1] <= sign_s[k];
                ovf_s[k+1]  <= ovf_s[k];
            end
        end
    end

    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_div
        emi_div_stage u_stage (
            .clk     (clk),
            .en      (en),
            .mass    (mass_s[k]),
            .rem_in  (rem_s[k]),
            .dq_in   (dq_s[k]),
            .rem_reg (rem_s[k+1]),
            .dq_reg  (dq_s[k+1])
        );
    end

    // acceleration: limit, sign, zero-mass override
    word_t  acc_next;
    logic   asat_next;
    logic   zero_next;

    always_comb
    begin
        uword_t q;
        uword_t lim;
        uword_t mag;
        logic   over;
        q         = dq_s[DIV_STAGES];
        lim       = {1'b0, {(WORD_WIDTH-1){1'b1}}} + uword_t'(sign_s[DIV_STAGES]);
        over      = ovf_s[DIV_STAGES] || (q > lim);
        mag       = over ? lim : q;
        zero_next = (mass_s[DIV_STAGES] == '0);
        if (zero_next)
        begin
            acc_next  = '0;
            asat_next = 1'b0;
        end
        else
        begin
            acc_next  = sign_s[DIV_STAGES] ? word_t'(-mag) : word_t'(mag);
            asat_next = over;
        end
    end

    word_t acc1_reg, pos1_reg, vel1_reg;
    logic  sat1_reg, zero1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            acc1_reg  <= acc_next;
            sat1_reg  <= asat_next;
            zero1_reg <= zero_next;
            pos1_reg  <= pos_s[DIV_STAGES];
            vel1_reg  <= vel_s[DIV_STAGES];
        end
    end

    // a * step
    logic [PROD_WIDTH-1:0] prod1_reg;
    word_t                 acc2_reg, pos2_reg, vel2_reg;
    logic                  neg1_reg, sat2_reg, zero2_reg;
    uword_t                amag;

    assign amag = acc1_reg[WORD_WIDTH-1] ? uword_t'(-acc1_reg) : uword_t'(acc1_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod1_reg <= PROD_WIDTH'(amag) * PROD_WIDTH'(step);
            neg1_reg  <= acc1_reg[WORD_WIDTH-1];
            acc2_reg  <= acc1_reg;
            pos2_reg  <= pos1_reg;
            vel2_reg  <= vel1_reg;
            sat2_reg  <= sat1_reg;
            zero2_reg <= zero1_reg;
        end
    end

    // round to nearest, ties away, then add to velocity and clamp
    logic [PROD_WIDTH-1:0]       rnd1;
    logic signed [SUM_WIDTH-1:0] vsum;
    logic [WORD_WIDTH:0]         vclamp;

    assign rnd1   = prod1_reg + (PROD_WIDTH'(1) << (STEP_FRAC - 1));
    assign vsum   = neg1_reg
                    ? $signed({{2{vel2_reg[WORD_WIDTH-1]}}, vel2_reg})
                      - $signed({2'b00, rnd1[PROD_WIDTH-1:STEP_FRAC]})
                    : $signed({{2{vel2_reg[WORD_WIDTH-1]}}, vel2_reg})
                      + $signed({2'b00, rnd1[PROD_WIDTH-1:STEP_FRAC]});
    assign vclamp = clamp_word(vsum);

    word_t nv3_reg, acc3_reg, pos3_reg;
    logic  sat3_reg, zero3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nv3_reg   <= vclamp[WORD_WIDTH-1:0];
            sat3_reg  <= sat2_reg | vclamp[WORD_WIDTH];
            acc3_reg  <= acc2_reg;
            pos3_reg  <= pos2_reg;
            zero3_reg <= zero2_reg;
        end
    end

    // new velocity * step
    logic [PROD_WIDTH-1:0] prod2_reg;
    word_t                 nv4_reg, acc4_reg, pos4_reg;
    logic                  neg2_reg, sat4_reg, zero4_reg;
    uword_t                vmag;

    assign vmag = nv3_reg[WORD_WIDTH-1] ? uword_t'(-nv3_reg) : uword_t'(nv3_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod2_reg <= PROD_WIDTH'(vmag) * PROD_WIDTH'(step);
            neg2_reg  <= nv3_reg[WORD_WIDTH-1];
            nv4_reg   <= nv3_reg;
            acc4_reg  <= acc3_reg;
            pos4_reg  <= pos3_reg;
            sat4_reg  <= sat3_reg;
            zero4_reg <= zero3_reg;
        end
    end

    logic [PROD_WIDTH-1:0]       rnd2;
    logic signed [SUM_WIDTH-1:0] psum;
    logic [WORD_WIDTH:0]         pclamp;

    assign rnd2   = prod2_reg + (PROD_WIDTH'(1) << (STEP_FRAC - 1));
    assign psum   = neg2_reg
                    ? $signed({{2{pos4_reg[WORD_WIDTH-1]}}, pos4_reg})
                      - $signed({2'b00, rnd2[PROD_WIDTH-1:STEP_FRAC]})
                    : $signed({{2{pos4_reg[WORD_WIDTH-1]}}, pos4_reg})
                      + $signed({2'b00, rnd2[PROD_WIDTH-1:STEP_FRAC]});
    assign pclamp = clamp_word(psum);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg.pos  <= pclamp[WORD_WIDTH-1:0];
            res_reg.vel  <= nv4_reg;
            res_reg.acc  <= acc4_reg;
            res_reg.zero <= zero4_reg;
            res_reg.sat  <= sat4_reg | pclamp[WORD_WIDTH];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/euler_motion_integrator_top.sv =====
// ----------------------------------------------------------------------------
// Euler motion integrator
// Semi-implicit Euler step for one entity per transaction, three axes.
// ----------------------------------------------------------------------------
// Accepts one transaction per clock while the output is not stalled, and returns
// each result after it passes an input register, 8 divider stages of 4 quotient
// bits each for force / mass, then acceleration limiting, the velocity product,
// the velocity sum, the position product and the position sum. The whole pipeline
// holds while a finished result waits on out_ready. The user must write time_step
// via cfg_we/cfg_wdata only while the pipeline is empty; the block does not enforce it.
`default_nettype none

module euler_motion_integrator_top
    import emi_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  cfg_we,
    input  wire step_t cfg_wdata,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire in_t   in_item,
    output logic       out_valid,
    input  wire logic  out_ready,
    output out_t       out_item
);

    step_t                 time_step_reg;
    logic [PIPE_DEPTH-1:0] valid_reg;
    logic                  en;
    lane_out_t             res_x, res_y, res_z;

    assign en       = !valid_reg[PIPE_DEPTH-1] || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_step_reg <= TIME_STEP_RESET;
        end
        else if (cfg_we)
        begin
            time_step_reg <= cfg_wdata;
        end
    end

    // valid bits advance with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[PIPE_DEPTH-2:0], in_valid};
        end
    end

    emi_lane u_lane_x (
        .clk      (clk),
        .en       (en),
        .pos      (in_item.pos_x),
        .vel      (in_item.vel_x),
        .force_in (in_item.force_x),
        .mass     (in_item.body_mass),
        .step     (time_step_reg),
        .res_reg  (res_x)
    );

    emi_lane u_lane_y (
        .clk      (clk),
        .en       (en),
        .pos      (in_item.pos_y),
        .vel      (in_item.vel_y),
        .force_in (in_item.force_y),
        .mass     (in_item.body_mass),
        .step     (time_step_reg),
        .res_reg  (res_y)
    );

    emi_lane u_lane_z (
        .clk      (clk),
        .en       (en),
        .pos      (in_item.pos_z),
        .vel      (in_item.vel_z),
        .force_in (in_item.force_z),
        .mass     (in_item.body_mass),
        .step     (time_step_reg),
        .res_reg  (res_z)
    );

    assign out_valid          = valid_reg[PIPE_DEPTH-1];
    assign out_item.new_pos_x = res_x.pos;
    assign out_item.new_pos_y = res_y.pos;
    assign out_item.new_pos_z = res_z.pos;
    assign out_item.new_vel_x = res_x.vel;
    assign out_item.new_vel_y = res_y.vel;
    assign out_item.new_vel_z = res_z.vel;
    assign out_item.accel_x   = res_x.acc;
    assign out_item.accel_y   = res_y.acc;
    assign out_item.accel_z   = res_z.acc;
    // zero flag is identical in every lane
    assign out_item.mass_zero = res_x.zero & res_y.zero & res_z.zero;
    assign out_item.saturated = res_x.sat | res_y.sat | res_z.sat;

endmodule

`default_nettype wire

// ===== rtl/emi_checker.sv =====
// ----------------------------------------------------------------------------
// Euler motion integrator checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "euler_motion_integrator_top_defines.svh"

module emi_checker
    import emi_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_ready,
    input  wire logic out_valid,
    input  wire logic out_ready,
    input  wire out_t out_item
);

    // a stalled result holds
    `EMI_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_item))

    // the pipeline takes a transaction whenever its last stage can move
    `EMI_ASSERT_IMPL(a_ready_free, !out_valid || out_ready, in_ready)

    // zero mass forces zero acceleration
    `EMI_ASSERT_IMPL(a_zero_accel, out_valid && out_item.mass_zero,
        out_item.accel_x == '0 && out_item.accel_y == '0 && out_item.accel_z == '0)

endmodule

bind euler_motion_integrator_top emi_checker u_emi_checker (.*);

`default_nettype wire

// ===== tb/tb_euler_motion_integrator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Euler motion integrator testbench
// Streams entity transactions through the integrator under random bursts and
// output stalls, predicts each step in fixed point and checks every result
// field in order. The time step is changed between phases while idle.
// ----------------------------------------------------------------------------

module tb_euler_motion_integrator_top;
    import emi_pkg::*;

    localparam int LATENCY     = 14;
    localparam int CYCLE_LIMIT = 400000;

    logic  clk;
    logic  rst_n;
    logic  cfg_we;
    step_t cfg_wdata;
    logic  in_valid;
    logic  in_ready;
    in_t   in_item;
    logic  out_valid;
    logic  out_ready;
    out_t  out_item;

    euler_motion_integrator_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    in_t   pending_entities[$];
    out_t  expected_steps[$];
    step_t step_now;
    int    error_count = 0;
    int    cycle_count = 0;
    int    burst_left;
    int    gap_left;
    int    hold_off_left;
    bit    hold_off_request;
    bit    sender_paused;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic add_pending(in_t e);
        pending_entities = {pending_entities, e};
    endtask

    task automatic add_expected(out_t r);
        expected_steps = {expected_steps, r};
    endtask

    function automatic longint wrap_word(longint v, ref bit sat);
        if (v > 64'sd2147483647)
        begin
            sat = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            sat = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic longint scale_step(longint v, step_t dt);
        logic [63:0] mag;
        logic [63:0] prod;
        logic [63:0] r;
        mag  = (v < 0) ? 64'(-v) : 64'(v);
        prod = mag * {32'd0, dt};
        r    = (prod + 64'h8000_0000) >> 32;
        return (v < 0) ? -longint'(r) : longint'(r);
    endfunction

    function automatic out_t integrate_entity(in_t e, step_t dt);
        out_t   r;
        bit     sat;
        bit     zero;
        longint p[3];
        longint v[3];
        longint f[3];
        longint a;
        longint nv;
        longint np;
        logic [63:0] q;
        logic [63:0] lim;
        sat  = 1'b0;
        zero = (e.body_mass == 0);
        p = '{longint'(e.pos_x), longint'(e.pos_y), longint'(e.pos_z)};
        v = '{longint'(e.vel_x), longint'(e.vel_y), longint'(e.vel_z)};
        f = '{longint'(e.force_x), longint'(e.force_y), longint'(e.force_z)};
        r = '0;
        for (int k = 0; k < 3; k++)
        begin
            if (zero)
                a = 0;
            else
            begin
                q   = (((f[k] < 0) ? 64'(-f[k]) : 64'(f[k])) << FRAC_BITS)
                      / {32'd0, e.body_mass};
                lim = 64'h7FFF_FFFF + ((f[k] < 0) ? 64'd1 : 64'd0);
                if (q > lim)
                begin
                    sat = 1'b1;
                    q   = lim;
                end
                a = (f[k] < 0) ? -longint'(q) : longint'(q);
            end
            nv = wrap_word(v[k] + scale_step(a, dt), sat);
            np = wrap_word(p[k] + scale_step(nv, dt), sat);
            case (k)
                0:
                begin
                    r.new_pos_x = np[31:0];
                    r.new_vel_x = nv[31:0];
                    r.accel_x   = a[31:0];
                end
                1:
                begin
                    r.new_pos_y = np[31:0];
                    r.new_vel_y = nv[31:0];
                    r.accel_y   = a[31:0];
                end
                default:
                begin
                    r.new_pos_z = np[31:0];
                    r.new_vel_z = nv[31:0];
                    r.accel_z   = a[31:0];
                end
            endcase
        end
        r.mass_zero = zero;
        r.saturated = sat;
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        error_count++;
        $display("MISMATCH %s: got %h expected %h at %0t", field, got, want, $time);
    endtask

    // driver: bursts and gaps; expectations are taken at acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            in_item    <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else
        begin
            automatic bit busy = in_valid && !in_ready;
            if (in_valid && in_ready)
                add_expected(integrate_entity(in_item, step_now));
            if (!busy)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_entities.size() > 0 && !sender_paused)
                begin
                    in_valid <= 1'b1;
                    in_item  <= pending_entities.pop_front();
                    if (burst_left > 0)
                        burst_left <= burst_left - 1;
                    else
                    begin
                        burst_left <= $urandom_range(0, 30);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor: own stall pattern plus one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready     <= 1'b0;
            hold_off_left <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_steps.size() == 0)
                begin
                    error_count++;
                    $display("UNEXPECTED result at %0t", $time);
                end
                else
                begin
                    automatic out_t w = expected_steps.pop_front();
                    if (out_item.new_pos_x !== w.new_pos_x)
                        report_mismatch("new_pos_x", out_item.new_pos_x, w.new_pos_x);
                    if (out_item.new_pos_y !== w.new_pos_y)
                        report_mismatch("new_pos_y", out_item.new_pos_y, w.new_pos_y);
                    if (out_item.new_pos_z !== w.new_pos_z)
                        report_mismatch("new_pos_z", out_item.new_pos_z, w.new_pos_z);
                    if (out_item.new_vel_x !== w.new_vel_x)
                        report_mismatch("new_vel_x", out_item.new_vel_x, w.new_vel_x);
                    if (out_item.new_vel_y !== w.new_vel_y)
                        report_mismatch("new_vel_y", out_item.new_vel_y, w.new_vel_y);
                    if (out_item.new_vel_z !== w.new_vel_z)
                        report_mismatch("new_vel_z", out_item.new_vel_z, w.new_vel_z);
                    if (out_item.accel_x !== w.accel_x)
                        report_mismatch("accel_x", out_item.accel_x, w.accel_x);
                    if (out_item.accel_y !== w.accel_y)
                        report_mismatch("accel_y", out_item.accel_y, w.accel_y);
                    if (out_item.accel_z !== w.accel_z)
                        report_mismatch("accel_z", out_item.accel_z, w.accel_z);
                    if (out_item.mass_zero !== w.mass_zero)
                        report_mismatch("mass_zero", 32'(out_item.mass_zero),
                                        32'(w.mass_zero));
                    if (out_item.saturated !== w.saturated)
                        report_mismatch("saturated", 32'(out_item.saturated),
                                        32'(w.saturated));
                end
            end
            if (hold_off_request && hold_off_left == 0)
            begin
                hold_off_left <= 200;
                out_ready     <= 1'b0;
            end
            else if (hold_off_left > 0)
            begin
                hold_off_left <= hold_off_left - 1;
                out_ready     <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(0, 3) != 0) || (cycle_count[9:7] == 3'd5);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic logic [31:0] rand_word(int style);
        case (style)
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0;
            3: return $urandom_range(0, 32'h0003_FFFF) ^ {32{$urandom_range(0, 1) == 1}};
            default: return $urandom;
        endcase
    endfunction

    function automatic in_t rand_entity();
        in_t e;
        e.pos_x   = rand_word($urandom_range(0, 9));
        e.pos_y   = rand_word($urandom_range(0, 9));
        e.pos_z   = rand_word($urandom_range(0, 9));
        e.vel_x   = rand_word($urandom_range(0, 9));
        e.vel_y   = rand_word($urandom_range(0, 9));
        e.vel_z   = rand_word($urandom_range(0, 9));
        e.force_x = rand_word($urandom_range(0, 9));
        e.force_y = rand_word($urandom_range(0, 9));
        e.force_z = rand_word($urandom_range(0, 9));
        case ($urandom_range(0, 9))
            0:       e.body_mass = 32'h0;
            1:       e.body_mass = 32'hFFFF_FFFF;
            2:       e.body_mass = $urandom_range(1, 16);
            3, 4:    e.body_mass = $urandom_range(32'h0000_8000, 32'h0010_0000);
            default: e.body_mass = $urandom;
        endcase
        return e;
    endfunction

    task automatic wait_idle();
        while (pending_entities.size() > 0 || in_valid || expected_steps.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_step(step_t value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        step_now  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        step_t steps[6];
        in_t   e;
        steps = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h8000_0000, 32'd65536, 32'd0};
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_wdata        = '0;
        step_now         = TIME_STEP_RESET;
        hold_off_request = 1'b0;
        sender_paused    = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed extremes under the reset step
        e = '{default: 32'h7FFF_FFFF, body_mass: 32'd1};
        add_pending(e);
        e = '{default: 32'h8000_0000, body_mass: 32'd1};
        add_pending(e);
        e = '{default: 32'h0, body_mass: 32'h0};
        add_pending(e);
        e = '{default: 32'h8000_0000, body_mass: 32'h0};
        add_pending(e);
        e = '{default: 32'hFFFF_FFFF, body_mass: 32'hFFFF_FFFF};
        add_pending(e);
        e = '{default: 32'h0001_0000, body_mass: 32'h0001_0000};
        add_pending(e);
        e = '{default: 32'hFFFF_0000, body_mass: 32'h0000_8000};
        add_pending(e);
        wait_idle();

        write_step(32'hFFFF_FFFF);
        for (int i = 0; i < 8; i++)
            add_pending(rand_entity());
        e = '{default: 32'h7FFF_FFFF, body_mass: 32'h0001_0000};
        add_pending(e);
        e = '{default: 32'h8000_0000, body_mass: 32'h0001_0000};
        add_pending(e);
        wait_idle();

        for (int ph = 0; ph < 6; ph++)
        begin
            write_step((ph == 5) ? step_t'($urandom) : steps[ph]);
            for (int i = 0; i < 140; i++)
                add_pending(rand_entity());
            if (ph == 2)
            begin
                // hold the output long enough for the pipeline to back up
                repeat (20) @(posedge clk);
                @(negedge clk);
                hold_off_request = 1'b1;
                @(negedge clk);
                hold_off_request = 1'b0;
            end
            if (ph == 3)
            begin
                repeat (60) @(posedge clk);
                sender_paused = 1'b1;
                while (expected_steps.size() > 0 || in_valid)
                    @(posedge clk);
                sender_paused = 1'b0;
            end
            wait_idle();
        end

        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
